// ===== rtl/ismet_pkg.sv =====
// Shared constants, codes and types for the Ising lattice Metropolis site update block.
package ismet_pkg;

  // Lattice geometry
  localparam int ROWS   = 32;
  localparam int COLS   = 32;
  localparam int SITES  = ROWS * COLS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);

  // Field widths
  localparam int SITE_W   = 10;
  localparam int DRAW_W   = 16;
  localparam int THR_W    = 17;
  localparam int ENERGY_W = 13;
  localparam int MAGNET_W = 12;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register index codes (word index, paddr[2])
  localparam logic REG_THR_FOUR  = 1'b0;
  localparam logic REG_THR_EIGHT = 1'b1;

  // Item mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_FLIP = 1'b1;

  // Totals after reset: every spin up
  localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITES);
  localparam logic [MAGNET_W-1:0] MAGNET_RESET = MAGNET_W'(SITES);

  // Everything the flip decision needs for one site
  typedef struct packed {
    logic                in_range;
    logic                mode;
    logic                spin_value;
    logic [DRAW_W-1:0]   draw;
    logic                self_spin;
    logic                up_spin;
    logic                dn_spin;
    logic                lf_spin;
    logic                rt_spin;
    logic [THR_W-1:0]    thr_four;
    logic [THR_W-1:0]    thr_eight;
    logic [ENERGY_W-1:0] energy;
    logic [MAGNET_W-1:0] magnet;
  } eval_in_t;

  // Decision and updated totals
  typedef struct packed {
    logic                flip;
    logic                spin_after;
    logic [ENERGY_W-1:0] energy;
    logic [MAGNET_W-1:0] magnet;
  } eval_out_t;

endpackage

// ===== rtl/ising_metropolis_site_update.sv =====
// Top level: Ising lattice with Metropolis single-site updates, stream in, stream out.
// Pipeline: a row read stage, then a result register.
// Throughput: one item per cycle unless the result stream stalls; the lattice is three row-wide
// memory copies, each read once per cycle, with the last written row forwarded to the next item.
// Reset: asynchronous, active low; lattice reads as all spins up via per-row valid bits,
// totals return to -2048 and 1024, thresholds to 0. No clearing pass is needed.
module ising_metropolis_site_update
  import ismet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // site[9:0], spin_value[10], random_draw[26:11], zero
  input  logic              s_axis_tuser,  // mode[0]
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata   // flipped[0], spin_after[1], total_energy[14:2],
                                           // magnetization[26:15], zero
);

  // Configuration registers
  logic [THR_W-1:0] thr_four_q, thr_eight_q;
  logic             cfg_wr;

  // Input field views
  logic [SITE_W-1:0] in_site;
  logic              in_spin;
  logic [DRAW_W-1:0] in_draw;
  logic [ROW_W-1:0]  row_d, row_up_d, row_dn_d;
  logic [COL_W-1:0]  col_d;
  logic              in_range_d;

  // Read stage
  logic              s1_valid_q;
  logic              s1_mode_q, s1_spin_q, s1_in_range_q;
  logic [DRAW_W-1:0] s1_draw_q;
  logic [ROW_W-1:0]  s1_row_q, s1_row_up_q, s1_row_dn_q;
  logic [COL_W-1:0]  s1_col_q, col_lf, col_rt;
  logic              vld_up_q, vld_mid_q, vld_dn_q;
  logic [COLS-1:0]   rd_up, rd_mid, rd_dn;
  logic [COLS-1:0]   eff_up, eff_mid, eff_dn;

  // Write-back and forwarding
  logic              wr_en;
  logic [COLS-1:0]   wr_row_data;
  logic              fwd_valid_q;
  logic [ROW_W-1:0]  fwd_row_q;
  logic [COLS-1:0]   fwd_data_q;
  logic [ROWS-1:0]   row_vld_q;

  // Totals and result register
  logic [ENERGY_W-1:0] energy_q;
  logic [MAGNET_W-1:0] magnet_q;
  logic                out_valid_q, out_flipped_q, out_spin_q;
  logic [ENERGY_W-1:0] out_energy_q;
  logic [MAGNET_W-1:0] out_magnet_q;

  logic      adv_out, adv_s1, in_acc;
  eval_in_t  ev_in;
  eval_out_t ev_out;

  // Configuration writes and reads
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_four_q  <= '0;
      thr_eight_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_THR_FOUR:  thr_four_q  <= pwdata[THR_W-1:0];
        REG_THR_EIGHT: thr_eight_q <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THR_FOUR:  prdata = APB_DW'(thr_four_q);
      REG_THR_EIGHT: prdata = APB_DW'(thr_eight_q);
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow control
  assign adv_out       = !out_valid_q || m_axis_tready;
  assign adv_s1        = !s1_valid_q || adv_out;
  assign s_axis_tready = adv_s1;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // Split the site into row and column with wrap-around neighbours
  always_comb begin
    in_site    = s_axis_tdata[SITE_W-1:0];
    in_spin    = s_axis_tdata[SITE_W];
    in_draw    = s_axis_tdata[SITE_W+DRAW_W:SITE_W+1];
    in_range_d = ({1'b0, in_site} < (SITE_W+1)'(SITES));
    row_d      = ROW_W'(in_site / COLS);
    col_d      = COL_W'(in_site % COLS);
    row_up_d   = (row_d == '0) ? ROW_W'(ROWS - 1) : row_d - 1'b1;
    row_dn_d   = (row_d == ROW_W'(ROWS - 1)) ? '0 : row_d + 1'b1;
  end

  // Three lattice copies, one per row read
  ismet_row_ram u_ram_up (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_row_q),
    .wdata_i (wr_row_data),
    .re_i    (adv_s1),
    .raddr_i (row_up_d),
    .rdata_o (rd_up)
  );

  ismet_row_ram u_ram_mid (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_row_q),
    .wdata_i (wr_row_data),
    .re_i    (adv_s1),
    .raddr_i (row_d),
    .rdata_o (rd_mid)
  );

  ismet_row_ram u_ram_dn (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_row_q),
    .wdata_i (wr_row_data),
    .re_i    (adv_s1),
    .raddr_i (row_dn_d),
    .rdata_o (rd_dn)
  );

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_q <= in_acc;
    end
  end

  // Read stage payload and row valid samples
  always_ff @(posedge clk_i) begin
    if (adv_s1) begin
      s1_mode_q     <= s_axis_tuser;
      s1_spin_q     <= in_spin;
      s1_draw_q     <= in_draw;
      s1_in_range_q <= in_range_d;
      s1_row_q      <= row_d;
      s1_row_up_q   <= row_up_d;
      s1_row_dn_q   <= row_dn_d;
      s1_col_q      <= col_d;
      vld_up_q      <= row_vld_q[row_up_d];
      vld_mid_q     <= row_vld_q[row_d];
      vld_dn_q      <= row_vld_q[row_dn_d];
    end
  end

  // Resolve rows: unwritten rows read all up, the row written last is forwarded
  always_comb begin
    eff_up  = vld_up_q  ? rd_up  : '1;
    eff_mid = vld_mid_q ? rd_mid : '1;
    eff_dn  = vld_dn_q  ? rd_dn  : '1;
    if (fwd_valid_q && fwd_row_q == s1_row_up_q) begin
      eff_up = fwd_data_q;
    end
    if (fwd_valid_q && fwd_row_q == s1_row_q) begin
      eff_mid = fwd_data_q;
    end
    if (fwd_valid_q && fwd_row_q == s1_row_dn_q) begin
      eff_dn = fwd_data_q;
    end
    col_lf = (s1_col_q == '0) ? COL_W'(COLS - 1) : s1_col_q - 1'b1;
    col_rt = (s1_col_q == COL_W'(COLS - 1)) ? '0 : s1_col_q + 1'b1;
  end

  // Gather the decision inputs
  always_comb begin
    ev_in.in_range   = s1_in_range_q;
    ev_in.mode       = s1_mode_q;
    ev_in.spin_value = s1_spin_q;
    ev_in.draw       = s1_draw_q;
    ev_in.self_spin  = eff_mid[s1_col_q];
    ev_in.up_spin    = eff_up[s1_col_q];
    ev_in.dn_spin    = eff_dn[s1_col_q];
    ev_in.lf_spin    = eff_mid[col_lf];
    ev_in.rt_spin    = eff_mid[col_rt];
    ev_in.thr_four   = thr_four_q;
    ev_in.thr_eight  = thr_eight_q;
    ev_in.energy     = energy_q;
    ev_in.magnet     = magnet_q;
  end

  ismet_flip_eval u_eval (
    .eval_i (ev_in),
    .eval_o (ev_out)
  );

  // Write the toggled row back when the item leaves the read stage
  always_comb begin
    wr_en       = s1_valid_q & adv_out & ev_out.flip;
    wr_row_data = eff_mid;
    wr_row_data[s1_col_q] = ~eff_mid[s1_col_q];
  end

  // Forwarding register tracks the write made alongside the next row read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (adv_s1) begin
      fwd_valid_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1) begin
      fwd_row_q  <= s1_row_q;
      fwd_data_q <= wr_row_data;
    end
  end

  // Mark rows that hold written data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en) begin
      row_vld_q[s1_row_q] <= 1'b1;
    end
  end

  // Advance totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= ENERGY_RESET;
      magnet_q <= MAGNET_RESET;
    end else if (s1_valid_q && adv_out) begin
      energy_q <= ev_out.energy;
      magnet_q <= ev_out.magnet;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s1_valid_q) begin
      out_flipped_q <= ev_out.flip;
      out_spin_q    <= ev_out.spin_after;
      out_energy_q  <= ev_out.energy;
      out_magnet_q  <= ev_out.magnet;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_magnet_q, out_energy_q, out_spin_q, out_flipped_q};

endmodule

// ===== rtl/ismet_row_ram.sv =====
// One copy of the spin lattice, stored one row per word, with a registered read port.
module ismet_row_ram
  import ismet_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ROW_W-1:0] waddr_i,
  input  logic [COLS-1:0]  wdata_i,
  input  logic             re_i,
  input  logic [ROW_W-1:0] raddr_i,
  output logic [COLS-1:0]  rdata_o
);

  logic [COLS-1:0] mem [ROWS];

  // Write a whole row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read a whole row, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/ismet_flip_eval.sv =====
// Metropolis flip decision and incremental energy and magnetization update for one site.
module ismet_flip_eval
  import ismet_pkg::*;
(
  input  eval_in_t  eval_i,
  output eval_out_t eval_o
);

  logic [2:0]          ups;
  logic signed [3:0]   k_pos;
  logic signed [3:0]   k;
  logic [ENERGY_W-1:0] energy_step;
  logic                accept;
  logic                flip;

  // Count up neighbours; k is the energy change divided by four
  always_comb begin
    ups   = 3'(eval_i.up_spin) + 3'(eval_i.dn_spin) + 3'(eval_i.lf_spin) + 3'(eval_i.rt_spin);
    k_pos = $signed({1'b0, ups}) - 4'sd2;
    k     = eval_i.self_spin ? k_pos : -k_pos;
    energy_step = {{(ENERGY_W-6){k[3]}}, k, 2'b00};
  end

  // Decide the flip
  always_comb begin
    if (eval_i.mode == MODE_LOAD) begin
      accept = (eval_i.spin_value != eval_i.self_spin);
    end else if (k <= 4'sd0) begin
      accept = 1'b1;
    end else if (k == 4'sd1) begin
      accept = ({1'b0, eval_i.draw} < eval_i.thr_four);
    end else begin
      accept = ({1'b0, eval_i.draw} < eval_i.thr_eight);
    end
    flip = eval_i.in_range & accept;
  end

  // Update the totals
  always_comb begin
    eval_o.flip       = flip;
    eval_o.spin_after = eval_i.in_range & (eval_i.self_spin ^ flip);
    eval_o.energy     = flip ? eval_i.energy + energy_step : eval_i.energy;
    if (!flip) begin
      eval_o.magnet = eval_i.magnet;
    end else if (eval_i.self_spin) begin
      eval_o.magnet = eval_i.magnet - MAGNET_W'(2);
    end else begin
      eval_o.magnet = eval_i.magnet + MAGNET_W'(2);
    end
  end

endmodule

// ===== rtl/ismet_checker.sv =====
// Port-level checks for the Ising site update block, bound to the top level.
module ismet_checker
  import ismet_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic [MAGNET_W-1:0] prev_mag_q;
  logic [MAGNET_W-1:0] mag;
  logic [ENERGY_W-1:0] energy;
  logic                flipped, spin_after, out_acc;

  assign flipped    = m_axis_tdata[0];
  assign spin_after = m_axis_tdata[1];
  assign energy     = m_axis_tdata[14:2];
  assign mag        = m_axis_tdata[26:15];
  assign out_acc    = m_axis_tvalid & m_axis_tready;

  // Track the magnetization of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mag_q <= MAGNET_RESET;
    end else if (out_acc) begin
      prev_mag_q <= mag;
    end
  end

  // No result is offered in the cycle after reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Totals keep their lattice parity
  a_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> mag[0] == 1'b0 && energy[1:0] == 2'b00)
    else $error("totals lost their parity");

  // Magnetization moves by two exactly on a flip, toward the new spin
  a_mag_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (!flipped && mag == prev_mag_q) ||
                (flipped && spin_after && mag == prev_mag_q + MAGNET_W'(2)) ||
                (flipped && !spin_after && mag == prev_mag_q - MAGNET_W'(2)))
    else $error("magnetization step does not match the flip");

endmodule

bind ising_metropolis_site_update ismet_checker u_ismet_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb.sv =====
// Self-checking bench for the Ising lattice Metropolis site update block.
module tb;
  import ismet_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_PER_SETTING = 84;

  // Result fields, flipped in bit 0, as packed on m_axis_tdata
  typedef struct packed {
    logic [MAGNET_W-1:0] magnetization;
    logic [ENERGY_W-1:0] total_energy;
    logic                spin_after;
    logic                flipped;
  } site_result_t;

  // Tracks the lattice, totals and thresholds and predicts each result
  class spin_lattice_tracker;
    bit                  spins[SITES];
    logic [ENERGY_W-1:0] energy;
    logic [MAGNET_W-1:0] magnet;
    int unsigned         thr_four;
    int unsigned         thr_eight;
    site_result_t        pending_results[$];
    int                  mismatches;
    int                  items;
    int                  results;
    int                  spin_changes;

    function new();
      foreach (spins[i]) spins[i] = 1'b1;
      energy = ENERGY_W'(-2 * SITES);
      magnet = MAGNET_W'(SITES);
      thr_four = 0;
      thr_eight = 0;
      mismatches = 0;
      items = 0;
      results = 0;
      spin_changes = 0;
    endfunction

    function void set_threshold(logic idx, int unsigned value);
      if (idx == REG_THR_FOUR) thr_four = value & 32'h1FFFF;
      else thr_eight = value & 32'h1FFFF;
    endfunction

    function void mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Energy change 2*s*(neighbor sum) with wrap-around borders
    function int flip_cost(int site);
      int row;
      int col;
      int ups;
      int s;
      row = site / COLS;
      col = site % COLS;
      ups = int'(spins[((row + ROWS - 1) % ROWS) * COLS + col])
          + int'(spins[((row + 1) % ROWS) * COLS + col])
          + int'(spins[row * COLS + (col + COLS - 1) % COLS])
          + int'(spins[row * COLS + (col + 1) % COLS]);
      s = spins[site] ? 1 : -1;
      return 2 * s * (2 * ups - 4);
    endfunction

    // Apply one accepted item and queue the result it must produce
    function void apply_site_item(logic mode, logic [SITE_W-1:0] site, logic spin_value,
                                  logic [DRAW_W-1:0] draw);
      site_result_t want;
      int cost;
      bit flip;
      want = '0;
      items++;
      if (int'(site) < SITES) begin
        cost = flip_cost(site);
        if (mode == MODE_LOAD) flip = (spin_value != spins[site]);
        else if (cost <= 0) flip = 1'b1;
        else if (cost == 4) flip = (draw < thr_four);
        else flip = (draw < thr_eight);
        if (flip) begin
          energy = energy + ENERGY_W'(cost);
          magnet = spins[site] ? magnet - MAGNET_W'(2) : magnet + MAGNET_W'(2);
          spins[site] = ~spins[site];
          spin_changes++;
        end
        want.flipped = flip;
        want.spin_after = spins[site];
      end
      want.total_energy = energy;
      want.magnetization = magnet;
      pending_results = {pending_results, want};
    endfunction

    // Compare one result transaction with the oldest prediction
    function void compare_result(logic [31:0] data);
      site_result_t got;
      site_result_t want;
      got = data[26:0];
      results++;
      if (pending_results.size() == 0) begin
        mismatch($sformatf("result %h with nothing predicted", data));
        return;
      end
      want = pending_results.pop_front();
      if (got.flipped !== want.flipped || got.spin_after !== want.spin_after ||
          got.total_energy !== want.total_energy ||
          got.magnetization !== want.magnetization || data[31:27] !== 5'b0) begin
        mismatch($sformatf({"result %0d: flipped %b/%b spin_after %b/%b ",
                            "energy %0d/%0d magnetization %0d/%0d pad %b (exp/got)"},
                           results, want.flipped, got.flipped, want.spin_after,
                           got.spin_after, $signed(want.total_energy),
                           $signed(got.total_energy), $signed(want.magnetization),
                           $signed(got.magnetization), data[31:27]));
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;  // site[9:0], spin_value[10], random_draw[26:11], zero
  logic              s_axis_tuser;  // mode[0]
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;  // flipped[0], spin_after[1], total_energy[14:2],
                                    // magnetization[26:15], zero

  spin_lattice_tracker sb;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;
  int settings_run;

  ising_metropolis_site_update dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result stream at random
  always @(negedge clk_i) begin
    m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Record transactions on both streams and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.apply_site_item(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[10],
                           s_axis_tdata[26:11]);
      end
      if (m_axis_tvalid && m_axis_tready) sb.compare_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no stream transaction for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one item, idling at random first, and hold it until accepted
  task automatic send_item(input logic mode, input int site, input logic spin_value,
                           input logic [DRAW_W-1:0] draw);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {5'b0, draw, spin_value, SITE_W'(site)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop the input stream and hold until every predicted result is back
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One APB transaction; a read is checked against the given value
  task automatic apb_xfer(input logic write, input logic idx, input int unsigned value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (write) sb.set_threshold(idx, value);
    else if (prdata !== APB_DW'(value)) begin
      sb.mismatch($sformatf("register %0d read %0d, written %0d", idx, prdata, value));
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write both thresholds while idle and read them back
  task automatic program_thresholds(input int unsigned four, input int unsigned eight);
    wait_idle();
    apb_xfer(1'b1, REG_THR_FOUR, four);
    apb_xfer(1'b1, REG_THR_EIGHT, eight);
    apb_xfer(1'b0, REG_THR_FOUR, four);
    apb_xfer(1'b0, REG_THR_EIGHT, eight);
    settings_run++;
  endtask

  // Mostly attempts on a band of rows across the wrap, some anywhere
  task automatic send_random_item();
    logic              mode;
    int                site;
    logic [DRAW_W-1:0] draw;
    mode = ($urandom_range(99) < 60) ? MODE_FLIP : MODE_LOAD;
    if ($urandom_range(99) < 70) begin
      site = (($urandom_range(3) + ROWS - 2) % ROWS) * COLS + $urandom_range(COLS - 1);
    end else begin
      site = $urandom_range(SITES - 1);
    end
    case ($urandom_range(9))
      0: draw = '0;
      1: draw = '1;
      2: draw = DRAW_W'(sb.thr_four);
      3: draw = DRAW_W'(sb.thr_eight - 1);
      default: draw = DRAW_W'($urandom);
    endcase
    send_item(mode, site, 1'($urandom_range(1)), draw);
  endtask

  int unsigned four_set[6];
  int unsigned eight_set[6];

  initial begin
    sb = new();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_LOAD;
    m_axis_tready = 1'b0;
    stall_cycles = 0;
    settings_run = 0;
    send_idle_pct = 36;
    recv_idle_pct = 45;
    four_set = '{20000, 65536, 0, 45000, $urandom_range(65536), 1};
    eight_set = '{3000, 0, 65536, 12000, $urandom_range(65536), 65535};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Thresholds come out of reset at zero: no uphill flip attempt is accepted; loads still apply
    apb_xfer(1'b0, REG_THR_FOUR, 0);
    apb_xfer(1'b0, REG_THR_EIGHT, 0);
    send_item(MODE_FLIP, 0, 1'b1, 16'h0000);
    send_item(MODE_FLIP, SITES - 1, 1'b0, 16'h0000);
    send_item(MODE_LOAD, 0, 1'b0, 16'hFFFF);
    send_item(MODE_LOAD, 0, 1'b0, 16'h0000);
    send_item(MODE_FLIP, 0, 1'b0, 16'hFFFF);
    send_item(MODE_LOAD, 1, 1'b0, 16'h0000);
    send_item(MODE_FLIP, 0, 1'b1, 16'h0000);
    send_item(MODE_LOAD, COLS - 1, 1'b0, 16'hFFFF);
    send_item(MODE_FLIP, 0, 1'b1, 16'hFFFF);
    send_item(MODE_LOAD, SITES - 1, 1'b1, 16'hFFFF);
    send_item(MODE_LOAD, SITES - COLS, 1'b0, 16'h0000);

    // Full-scale thresholds accept every uphill move
    program_thresholds(65536, 65536);
    send_item(MODE_FLIP, 500, 1'b0, 16'hFFFF);
    send_item(MODE_FLIP, COLS + 1, 1'b1, 16'hFFFF);

    // Boundary of the draw comparison for both thresholds
    program_thresholds(32768, 1);
    send_item(MODE_FLIP, 600, 1'b0, 16'h0000);
    send_item(MODE_FLIP, 700, 1'b1, 16'h0001);
    send_item(MODE_LOAD, 101, 1'b0, 16'h0000);
    send_item(MODE_FLIP, 100, 1'b0, 16'h8000);
    send_item(MODE_FLIP, 100, 1'b1, 16'h7FFF);
    send_item(MODE_LOAD, SITES - 1, 1'b0, 16'h5555);
    send_item(MODE_LOAD, SITES - 1, 1'b1, 16'hAAAA);

    // Random phases: receiver-heavy idling, sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 36 : 0;
      for (int k = 0; k < 2; k++) begin
        program_thresholds(four_set[2 * phase + k], eight_set[2 * phase + k]);
        for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
          if (n == RANDOM_PER_SETTING / 2) wait_idle();
          send_random_item();
        end
      end
    end

    wait_idle();
    $display("Covered %0d site items (%0d spin changes) under %0d threshold settings,",
             sb.items, sb.spin_changes, settings_run + 1);
    $display("checked %0d results across three stall patterns, %0d mismatches",
             sb.results, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
